FILE: rtl/bctc_pkg.sv
// Package for the block cache tag controller: sizes, request codes, payload structs.
// No dependencies.
package bctc_pkg;
  localparam int ENTRIES  = 16;
  localparam int IDX_W    = $clog2(ENTRIES);
  localparam int TAG_BITS = 32;
  localparam int RANK_W   = IDX_W;

  localparam logic [2:0] REQ_READ  = 3'd0;
  localparam logic [2:0] REQ_PWRITE = 3'd1;
  localparam logic [2:0] REQ_FWRITE = 3'd2;
  localparam logic [2:0] REQ_FLUSH = 3'd3;
  localparam logic [2:0] REQ_CLOSE = 3'd4;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] blk_num;
    logic [3:0]  random_start;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic [3:0]  slot;
    logic        fetch_needed;
    logic        writeback_needed;
    logic [31:0] writeback_block;
    logic        last;
  } out_item_t;

  // classified request passed from front to back
  typedef enum logic [1:0] {
    CMD_ACCESS = 2'd0,
    CMD_FLUSH  = 2'd1,
    CMD_NOP    = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [2:0]         req_type;
    logic [TAG_BITS-1:0] tag;
    logic [IDX_W-1:0]   start;
    logic               inval;
  } cmd_t;
endpackage

FILE: rtl/bctc_front.sv
// Front end: accepts requests, classifies them and pushes commands into a two-deep queue.
// Depends on bctc_pkg.
module bctc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  bctc_pkg::in_item_t in_data,
  output logic              q_valid,
  input  logic              q_pop,
  output bctc_pkg::cmd_t    q_cmd
);
  bctc_pkg::cmd_t q_r [2];
  logic [1:0] cnt_r;
  bctc_pkg::cmd_t c;
  logic push;

  always_comb begin
    c.req_type = in_data.req_type;
    c.tag      = bctc_pkg::TAG_BITS'(in_data.blk_num);
    c.start    = in_data.random_start[bctc_pkg::IDX_W-1:0];
    c.inval    = (in_data.req_type == bctc_pkg::REQ_CLOSE);
    if (in_data.req_type == bctc_pkg::REQ_READ || in_data.req_type == bctc_pkg::REQ_PWRITE ||
        in_data.req_type == bctc_pkg::REQ_FWRITE) begin
      c.kind = bctc_pkg::CMD_ACCESS;
    end else if (in_data.req_type == bctc_pkg::REQ_FLUSH ||
                 in_data.req_type == bctc_pkg::REQ_CLOSE) begin
      c.kind = bctc_pkg::CMD_FLUSH;
    end else begin
      c.kind = bctc_pkg::CMD_NOP;
    end
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = q_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
    // push during a pop only happens with one entry held
    if (q_pop) begin
      q_r[0] <= push ? c : q_r[1];
    end else if (push) begin
      q_r[cnt_r[0]] <= c;
    end
  end
endmodule

FILE: rtl/bctc_back.sv
// Back end: tag store, lookup, victim scan, flush walk and output register.
// Depends on bctc_pkg.
module bctc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_pop,
  input  bctc_pkg::cmd_t     q_cmd,
  output logic               out_valid,
  input  logic               out_stall,
  output bctc_pkg::out_item_t out_data
);
  localparam int N  = bctc_pkg::ENTRIES;
  localparam int IW = bctc_pkg::IDX_W;
  localparam int RW = bctc_pkg::RANK_W;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FLUSH} state_t;
  state_t state_r, state_nxt;

  logic [N-1:0] valid_r, valid_nxt, dirty_r, dirty_nxt;
  logic [bctc_pkg::TAG_BITS-1:0] tag_r [N];
  logic [RW-1:0] rank_r [N];
  logic [RW-1:0] rank_nxt [N];

  logic [IW-1:0] bkt_r, bkt_nxt;
  logic          ovld_r, ovld_nxt;
  logic          pop_r, pop_nxt;
  bctc_pkg::out_item_t odat_r, odat_nxt;
  logic          tag_we;
  logic [IW-1:0] tag_wi;

  logic out_free;
  assign out_free  = !ovld_r || !out_stall;
  assign out_valid = ovld_r;
  assign out_data  = odat_r;
  assign q_pop     = pop_r;

  // lookup, free search, bucket search (one bucket per cycle)
  logic hit; logic [IW-1:0] hit_i;
  logic full; logic [IW-1:0] free_i;
  logic [N-1:0] inbkt, newest;
  logic bfound; logic [IW-1:0] bvic;
  logic [RW-1:0] vrank;
  logic [N-1:0] dmask; logic dany; logic [IW-1:0] d_i; logic dmore;
  always_comb begin
    hit = 1'b0; hit_i = '0; full = 1'b1; free_i = '0;
    bfound = 1'b0; bvic = '0; dany = 1'b0; d_i = '0; dmore = 1'b0;
    dmask = valid_r & dirty_r;
    for (int i = 0; i < N; i++) begin
      inbkt[i] = valid_r[i] && (tag_r[i][IW-1:0] == bkt_r);
    end
    // newest entry of the bucket is rank 0 among its members; ranks are unique
    for (int i = 0; i < N; i++) begin
      newest[i] = inbkt[i];
      for (int j = 0; j < N; j++) begin
        if (inbkt[j] && rank_r[j] < rank_r[i]) newest[i] = 1'b0;
      end
    end
    for (int i = N-1; i >= 0; i--) begin
      if (valid_r[i] && tag_r[i] == q_cmd.tag) begin hit = 1'b1; hit_i = IW'(i); end
      if (!valid_r[i]) begin full = 1'b0; free_i = IW'(i); end
      if (newest[i]) begin bfound = 1'b1; bvic = IW'(i); end
      if (dmask[i]) begin dany = 1'b1; d_i = IW'(i); end
    end
    for (int i = 0; i < N; i++) begin
      if (dmask[i] && IW'(i) != d_i) dmore = 1'b1;
    end
  end
  assign vrank = rank_r[bvic];

  always_comb begin
    state_nxt = state_r;
    valid_nxt = valid_r;
    dirty_nxt = dirty_r;
    bkt_nxt   = bkt_r;
    ovld_nxt  = ovld_r && out_stall;
    pop_nxt   = 1'b0;
    odat_nxt  = odat_r;
    tag_we    = 1'b0;
    tag_wi    = '0;
    for (int i = 0; i < N; i++) rank_nxt[i] = rank_r[i];
    case (state_r)
      S_IDLE: begin
        if (q_valid && !pop_r && out_free) begin
          case (q_cmd.kind)
            bctc_pkg::CMD_ACCESS: begin
              if (hit) begin
                if (q_cmd.req_type != bctc_pkg::REQ_READ) dirty_nxt[hit_i] = 1'b1;
                odat_nxt = '{1'b1, 4'(hit_i), 1'b0, 1'b0, 32'd0, 1'b1};
                ovld_nxt = 1'b1; pop_nxt = 1'b1;
              end else if (!full) begin
                for (int i = 0; i < N; i++)
                  if (valid_r[i]) rank_nxt[i] = rank_r[i] + RW'(1);
                valid_nxt[free_i] = 1'b1;
                tag_we = 1'b1; tag_wi = free_i;
                dirty_nxt[free_i] = (q_cmd.req_type != bctc_pkg::REQ_READ);
                rank_nxt[free_i]  = '0;
                odat_nxt = '{1'b0, 4'(free_i), q_cmd.req_type != bctc_pkg::REQ_FWRITE,
                             1'b0, 32'd0, 1'b1};
                ovld_nxt = 1'b1; pop_nxt = 1'b1;
              end else begin
                bkt_nxt = q_cmd.start; state_nxt = S_SCAN;
              end
            end
            bctc_pkg::CMD_FLUSH: state_nxt = S_FLUSH;
            default: begin
              odat_nxt = '{1'b0, 4'd0, 1'b0, 1'b0, 32'd0, 1'b1};
              ovld_nxt = 1'b1; pop_nxt = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        // cache full: all entries valid, some bucket is nonempty
        if (!bfound) begin
          bkt_nxt = bkt_r + IW'(1);
        end else if (out_free) begin
          for (int i = 0; i < N; i++) begin
            if (IW'(i) == bvic) rank_nxt[i] = '0;
            else if (rank_r[i] < vrank) rank_nxt[i] = rank_r[i] + RW'(1);
          end
          tag_we = 1'b1; tag_wi = bvic;
          dirty_nxt[bvic] = (q_cmd.req_type != bctc_pkg::REQ_READ);
          odat_nxt = '{1'b0, 4'(bvic), q_cmd.req_type != bctc_pkg::REQ_FWRITE,
                       dirty_r[bvic], dirty_r[bvic] ? 32'(tag_r[bvic]) : 32'd0, 1'b1};
          ovld_nxt = 1'b1; pop_nxt = 1'b1; state_nxt = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          if (dany) begin
            odat_nxt = '{1'b0, 4'(d_i), 1'b0, 1'b1, 32'(tag_r[d_i]), !dmore};
            dirty_nxt[d_i] = 1'b0;
          end else begin
            odat_nxt = '{1'b0, 4'd0, 1'b0, 1'b0, 32'd0, 1'b1};
          end
          ovld_nxt = 1'b1;
          if (!dmore) begin
            if (q_cmd.inval) begin valid_nxt = '0; dirty_nxt = '0; end
            pop_nxt = 1'b1; state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      dirty_r <= '0;
      ovld_r  <= 1'b0;
      pop_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      dirty_r <= dirty_nxt;
      ovld_r  <= ovld_nxt;
      pop_r   <= pop_nxt;
      bkt_r   <= bkt_nxt;
      odat_r  <= odat_nxt;
      for (int i = 0; i < N; i++) rank_r[i] <= rank_nxt[i];
      if (tag_we) tag_r[tag_wi] <= q_cmd.tag;
    end
  end
endmodule

FILE: rtl/block_cache_tag_controller.sv
// Block cache tag controller, top level: front queue plus back-end policy engine.
// A hit or free fill is decided from the queue head and registered into the output; a
// full-cache miss first scans buckets from random_start, skipping empty ones (up to ENTRIES-1).
// The back end takes no new access until its registered queue pop has taken effect; a flush
// gives one result per dirty entry, one per cycle while the output is not stalled.
// Reset (rst_n low, synchronous) empties the queue and marks every entry invalid and clean.
module block_cache_tag_controller (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bctc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bctc_pkg::out_item_t out_data
);
  logic           q_valid, q_pop;
  bctc_pkg::cmd_t q_cmd;

  // front: classify requests and buffer them
  bctc_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .q_valid, .q_pop, .q_cmd
  );

  // back: tag store, lookup, eviction scan and flush walk
  bctc_back u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_cmd,
    .out_valid, .out_stall, .out_data
  );
endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// Testbench for block_cache_tag_controller: drives random and directed requests,
// predicts cache tag/policy results in a scoreboard class. Depends on bctc_pkg.
module tb;
  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  bctc_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_stall;
  bctc_pkg::out_item_t out_data;

  // Cache policy predictor plus queue of expected results
  class cache_scoreboard;
    bit                  valid_q[bctc_pkg::ENTRIES];
    bit [31:0]           tag_q[bctc_pkg::ENTRIES];
    bit                  dirty_q[bctc_pkg::ENTRIES];
    int unsigned         rank_q[bctc_pkg::ENTRIES];
    bctc_pkg::out_item_t pending[$];
    int                  mismatches;

    function void clear();
      foreach (valid_q[i]) begin
        valid_q[i] = 0; dirty_q[i] = 0; tag_q[i] = 0; rank_q[i] = 0;
      end
    endfunction

    function void push_result(bit h, int s, bit f, bit w, bit [31:0] b, bit l);
      bctc_pkg::out_item_t r;
      r.hit = h; r.slot = s[3:0]; r.fetch_needed = f;
      r.writeback_needed = w; r.writeback_block = b; r.last = l;
      pending.push_back(r);
    endfunction

    function void predict_access(bit [2:0] req, bit [31:0] tag, bit [3:0] rnd);
      int slot;
      bit wb;
      bit [31:0] wbblk;
      int b;
      slot = bctc_pkg::ENTRIES; wb = 0; wbblk = 0;
      for (int i = 0; i < bctc_pkg::ENTRIES; i++)
        if (valid_q[i] && tag_q[i] == tag) begin
          if (req != bctc_pkg::REQ_READ) dirty_q[i] = 1;
          push_result(1, i, 0, 0, 0, 1);
          return;
        end
      for (int i = 0; i < bctc_pkg::ENTRIES; i++)
        if (!valid_q[i]) begin
          slot = i; break;
        end
      if (slot == bctc_pkg::ENTRIES) begin
        // victim: newest entry of first nonempty bucket from rnd, wrapping
        for (int d = 0; d < bctc_pkg::ENTRIES && slot == bctc_pkg::ENTRIES; d++) begin
          b = (rnd + d) % bctc_pkg::ENTRIES;
          for (int i = 0; i < bctc_pkg::ENTRIES; i++)
            if (valid_q[i] && (tag_q[i] % bctc_pkg::ENTRIES) == b &&
                (slot == bctc_pkg::ENTRIES || rank_q[i] < rank_q[slot]))
              slot = i;
        end
        if (dirty_q[slot]) begin
          wb = 1; wbblk = tag_q[slot];
        end
        for (int j = 0; j < bctc_pkg::ENTRIES; j++)
          if (valid_q[j] && rank_q[j] > rank_q[slot]) rank_q[j]--;
        valid_q[slot] = 0; dirty_q[slot] = 0;
      end
      for (int i = 0; i < bctc_pkg::ENTRIES; i++)
        if (valid_q[i]) rank_q[i]++;
      valid_q[slot] = 1; tag_q[slot] = tag;
      dirty_q[slot] = (req != bctc_pkg::REQ_READ); rank_q[slot] = 0;
      push_result(0, slot, req != bctc_pkg::REQ_FWRITE, wb, wbblk, 1);
    endfunction

    function void note_request(bctc_pkg::in_item_t it);
      int n;
      n = 0;
      if (it.req_type <= bctc_pkg::REQ_FWRITE) begin
        predict_access(it.req_type, it.blk_num, it.random_start);
        return;
      end
      if (it.req_type > bctc_pkg::REQ_CLOSE) begin
        push_result(0, 0, 0, 0, 0, 1);
        return;
      end
      for (int i = 0; i < bctc_pkg::ENTRIES; i++)
        if (valid_q[i] && dirty_q[i]) begin
          push_result(0, i, 0, 1, tag_q[i], 0);
          dirty_q[i] = 0;
          n++;
        end
      if (it.req_type == bctc_pkg::REQ_CLOSE) clear();
      if (n == 0) push_result(0, 0, 0, 0, 0, 1);
      else pending[$].last = 1;
    endfunction

    function void check_result(bctc_pkg::out_item_t got);
      bctc_pkg::out_item_t exp_r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p, got %p", exp_r, got);
      end
    endfunction
  endclass

  cache_scoreboard sb;
  int   idle_cycles;
  bit   sender_bursty;
  bit   receiver_bursty;
  bit   hold_receiver;
  bit [31:0] hot_blocks[8];

  block_cache_tag_controller DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    clk = 0; #6;
    clk = 1; #6;
  end

  // Offer one request; hold it until accepted. Random gap first if enabled.
  task automatic send_request(bit [2:0] req, bit [31:0] blk, bit [3:0] rnd);
    int gap;
    if (sender_bursty && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_data.req_type <= req;
    in_data.blk_num <= blk;
    in_data.random_start <= rnd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request('{req_type: req, blk_num: blk, random_start: rnd});
  endtask

  task automatic go_idle();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // Mostly hot blocks so hits, evictions and dirty writebacks all occur
  task automatic random_request();
    bit [2:0] req;
    bit [31:0] blk;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) req = bctc_pkg::REQ_READ;
    else if (pick < 55) req = bctc_pkg::REQ_PWRITE;
    else if (pick < 80) req = bctc_pkg::REQ_FWRITE;
    else if (pick < 88) req = bctc_pkg::REQ_FLUSH;
    else if (pick < 93) req = bctc_pkg::REQ_CLOSE;
    else req = 3'($urandom_range(5, 7));
    if ($urandom_range(0, 2) != 0) blk = hot_blocks[$urandom_range(0, 7)] +
                                         32'($urandom_range(0, 3) * bctc_pkg::ENTRIES);
    else blk = $urandom;
    send_request(req, blk, 4'($urandom_range(0, 15)));
  endtask

  // Receiver: random stall bursts, or a long hold when asked
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 0;
    end else if (hold_receiver) begin
      out_stall <= 1;
    end else if (receiver_bursty && !out_stall && $urandom_range(0, 4) == 0) begin
      out_stall <= 1;
    end else if (out_stall && (!receiver_bursty || $urandom_range(0, 2) == 0)) begin
      out_stall <= 0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Watchdog: cycles with no handshake on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    sb = new();
    sb.clear();
    sb.mismatches = 0;
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    sender_bursty = 0;
    receiver_bursty = 0;
    hold_receiver = 0;
    foreach (hot_blocks[i]) hot_blocks[i] = $urandom;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: flush of an empty cache, unknown codes, field extremes
    send_request(bctc_pkg::REQ_FLUSH, 32'h0, 4'h0);
    send_request(3'd7, 32'hFFFF_FFFF, 4'hF);
    send_request(3'd5, 32'h0, 4'h0);
    // fill all 16 entries: first eight share bucket 0, rest take buckets 8 to 15
    for (int i = 0; i < bctc_pkg::ENTRIES; i++)
      send_request(3'(i % 3), (i < 8) ? 32'(i * bctc_pkg::ENTRIES) : 32'hFFFF_FFF0 + 32'(i),
                   4'(i));
    send_request(bctc_pkg::REQ_PWRITE, 32'h0, 4'h0);          // hit on write
    send_request(bctc_pkg::REQ_READ, 32'hFFFF_FFFF, 4'h0);    // hit on read
    send_request(bctc_pkg::REQ_READ, 32'h1234_5671, 4'hF);    // full miss, evicts bucket 15
    send_request(bctc_pkg::REQ_FWRITE, 32'h8000_0003, 4'hF);  // full miss, scan wraps, no fetch
    send_request(bctc_pkg::REQ_FLUSH, 32'hFFFF_FFFF, 4'hF);
    send_request(bctc_pkg::REQ_CLOSE, 32'h0, 4'h0);
    send_request(bctc_pkg::REQ_CLOSE, 32'h0, 4'h0);           // close with nothing dirty
    go_idle();

    // Random with idling both sides
    sender_bursty = 1;
    receiver_bursty = 1;
    repeat (100) random_request();

    // Long receiver hold while the sender keeps offering
    fork
      begin
        hold_receiver = 1;
        repeat (60) @(posedge clk);
        hold_receiver = 0;
      end
      repeat (30) random_request();
    join
    go_idle();

    repeat (90) random_request();

    // Last part: no idling
    sender_bursty = 0;
    receiver_bursty = 0;
    repeat (40) random_request();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

FILE: block_cache_tag_controller.f
rtl/bctc_pkg.sv
rtl/bctc_front.sv
rtl/bctc_back.sv
rtl/block_cache_tag_controller.sv
verif/tb.sv
